@@ rtl/psra_pkg.sv @@
// Package for the per-sensor running average table.
// Holds the beat types, status codes and fixed constants; no dependencies.
package psra_pkg;

    typedef struct packed {
        logic               command;
        logic [13:0]        sensor_id;
        logic signed [15:0] temperature;
    } t_in_beat;

    typedef struct packed {
        logic               kind;
        logic [2:0]         status;
        logic [15:0]        source_router;
        logic [13:0]        result_sensor;
        logic signed [15:0] average;
        logic               last;
    } t_out_beat;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_SENTINEL = 3'd3;
    localparam logic [2:0] ST_SAT      = 3'd4;

    localparam logic       CMD_REPORT = 1'b0;
    localparam logic       CMD_TICK   = 1'b1;
    localparam logic       KIND_STATUS  = 1'b0;
    localparam logic       KIND_AVERAGE = 1'b1;

    localparam logic signed [15:0] SENTINEL_TEMP = -16'sd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the input beat
        logic idx_clr;     // index to zero
        logic idx_inc;     // advance index
        logic cmp;         // latch the table read
        logic upd;         // write updated sum/count at the found index
        logic append;      // write a new entry at slots_used
        logic clr_entry;   // write zero sum/count at the index
        logic div_start;   // start division
        logic ld_status;   // load report result into output
        logic ld_avg;      // load average result into output
        logic [2:0] status;
        logic set_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic is_sentinel;
        logic idx_at_end;   // index equals slots_used
        logic hit;          // latched entry matches id
        logic nonzero;      // latched entry has count > 0
        logic saturated;    // latched count at its maximum
        logic full;         // slots_used at capacity
        logic div_done;
        logic any_left;     // a later entry has nonzero count
    } t_stat;

endpackage

@@ rtl/psra_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module psra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/psra_div.sv @@
// Serial restoring divider: signed 32-bit sum by unsigned count, truncating.
// Depends on nothing but its parameters; one quotient bit per cycle.
module psra_div #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [31:0]    i_dividend,
    input  logic [COUNT_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic signed [15:0]    o_quot
);
    localparam int CW = $clog2(33);

    logic [31:0]           r_q;
    logic [COUNT_BITS:0]   r_rem;
    logic [COUNT_BITS-1:0] r_d;
    logic                  r_neg;
    logic                  r_busy;
    logic [CW-1:0]         r_cnt;
    logic [COUNT_BITS:0]   n_trial;
    logic [COUNT_BITS:0]   n_shift;
    logic signed [32:0]    n_sq;

    always_comb begin
        n_shift = {r_rem[COUNT_BITS-1:0], r_q[31]};
        n_trial = n_shift - {1'b0, r_d};
    end

    // Shift one dividend bit in per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(32);
                r_neg  <= i_dividend[31];
                r_q    <= i_dividend[31] ? 32'(-i_dividend) : 32'(i_dividend);
                r_rem  <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                if (!n_trial[COUNT_BITS]) begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Sign and clamp to 16 bits.
    always_comb begin
        n_sq = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        if (n_sq > 33'sd32767) begin
            o_quot = 16'sh7fff;
        end else if (n_sq < -33'sd32768) begin
            o_quot = 16'sh8000;
        end else begin
            o_quot = n_sq[15:0];
        end
    end
endmodule

@@ rtl/psra_datapath.sv @@
// Datapath: table memories, index, compare, accumulate, divider, output beat.
// Depends on psra_pkg, psra_ram and psra_div.
module psra_datapath
    import psra_pkg::*;
#(
    parameter int MAX_SENSORS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_beat    i_beat,
    input  logic [15:0] i_router_id,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output t_out_beat   o_beat
);
    localparam int AW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int UW = $clog2(MAX_SENSORS + 1);
    localparam int EW = 14 + 32 + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    t_in_beat              r_in;
    logic [UW-1:0]         r_used;
    logic [UW-1:0]         r_idx;
    logic [MAX_SENSORS-1:0] r_nz;
    logic [EW-1:0]         w_rdata;
    logic [13:0]           r_sen;
    logic signed [31:0]    r_sum;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [EW-1:0]         w_wdata;
    logic signed [32:0]    n_acc;
    logic signed [31:0]    n_sat;
    logic                  w_done;
    logic signed [15:0]    w_quot;
    logic [MAX_SENSORS-1:0] w_later;

    // Saturating accumulate of the latched entry.
    always_comb begin
        n_acc = 33'(r_sum) + 33'(r_in.temperature);
        if (n_acc > 33'sh0_7fff_ffff) begin
            n_sat = 32'sh7fff_ffff;
        end else if (n_acc < -33'sh0_8000_0000) begin
            n_sat = 32'sh8000_0000;
        end else begin
            n_sat = n_acc[31:0];
        end
    end

    // Table write selection.
    always_comb begin
        w_we    = i_cmd.upd | i_cmd.append | i_cmd.clr_entry;
        w_waddr = i_cmd.append ? r_used[AW-1:0] : r_idx[AW-1:0];
        if (i_cmd.append) begin
            w_wdata = {r_in.sensor_id, 32'(r_in.temperature), COUNT_BITS'(1)};
        end else if (i_cmd.upd) begin
            w_wdata = {r_sen, n_sat, r_cnt + COUNT_BITS'(1)};
        end else begin
            w_wdata = {r_sen, 32'sd0, COUNT_BITS'(0)};
        end
    end

    psra_ram #(.WIDTH(EW), .DEPTH(MAX_SENSORS)) u_tab (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(w_rdata)
    );

    psra_div #(.COUNT_BITS(COUNT_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(r_sum),
        .i_divisor (r_cnt),
        .o_done    (w_done),
        .o_quot    (w_quot)
    );

    // Nonzero entries beyond the index.
    always_comb begin
        for (int k = 0; k < MAX_SENSORS; k++) begin
            w_later[k] = r_nz[k] && (UW'(k) > r_idx);
        end
    end

    // Control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_idx  <= '0;
            r_nz   <= '0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + UW'(1);
            end
            if (i_cmd.append) begin
                r_used <= r_used + UW'(1);
                r_nz[r_used[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.upd) begin
                r_nz[r_idx[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.clr_entry) begin
                r_nz[r_idx[AW-1:0]] <= 1'b0;
            end
        end
        if (i_cmd.capture) begin
            r_in <= i_beat;
        end
        if (i_cmd.cmp) begin
            {r_sen, r_sum, r_cnt} <= w_rdata;
        end
        if (i_cmd.ld_status) begin
            o_beat <= '{kind: KIND_STATUS, status: i_cmd.status, source_router: '0,
                        result_sensor: r_in.sensor_id, average: '0, last: 1'b1};
        end else if (i_cmd.ld_avg) begin
            o_beat <= '{kind: KIND_AVERAGE, status: ST_ADDED, source_router: i_router_id,
                        result_sensor: r_sen, average: w_quot, last: i_cmd.set_last};
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.is_tick     = (r_in.command == CMD_TICK);
        o_stat.is_sentinel = (r_in.temperature == SENTINEL_TEMP);
        o_stat.idx_at_end  = (r_idx == r_used);
        o_stat.hit         = (r_sen == r_in.sensor_id);
        o_stat.nonzero     = (r_cnt != '0);
        o_stat.saturated   = (r_cnt == CMAX);
        o_stat.full        = (r_used == UW'(MAX_SENSORS));
        o_stat.div_done    = w_done;
        o_stat.any_left    = |w_later;
    end
endmodule

@@ rtl/psra_ctrl.sv @@
// Controller state machine for the running average table.
// Depends on psra_pkg.
module psra_ctrl
    import psra_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_READ, S_CMP, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic   r_tick_more;

    assign o_in_ready = (r_state == S_IDLE) && !o_out_valid;

    // Command decode for each state.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid && o_in_ready;
                o_cmd.idx_clr = 1'b1;
            end
            S_DECIDE: begin
                if (!i_stat.is_tick && i_stat.is_sentinel) begin
                    o_cmd.ld_status = 1'b1;
                    o_cmd.status    = ST_SENTINEL;
                end else if (!i_stat.is_tick && i_stat.idx_at_end) begin
                    o_cmd.ld_status = 1'b1;
                    o_cmd.status    = i_stat.full ? ST_FULL : ST_NEW;
                    o_cmd.append    = !i_stat.full;
                end
            end
            S_READ: o_cmd.cmp = 1'b1;
            S_CMP: begin
                if (!i_stat.is_tick) begin
                    if (i_stat.hit) begin
                        o_cmd.ld_status = 1'b1;
                        o_cmd.status    = i_stat.saturated ? ST_SAT : ST_ADDED;
                        o_cmd.upd       = !i_stat.saturated;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end else if (i_stat.nonzero) begin
                    o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.ld_avg    = 1'b1;
                    o_cmd.set_last  = !i_stat.any_left;
                    o_cmd.clr_entry = 1'b1;
                end
            end
            S_OUT: o_cmd.idx_inc = i_out_ready && r_tick_more;
            default: o_cmd = '0;
        endcase
    end

    // State and the registered output-valid handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_tick_more <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (o_cmd.capture) r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (o_cmd.ld_status) begin
                        o_out_valid <= 1'b1;
                        r_tick_more <= 1'b0;
                        r_state     <= S_OUT;
                    end else if (i_stat.idx_at_end) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_CMP;
                S_CMP: begin
                    if (o_cmd.ld_status) begin
                        o_out_valid <= 1'b1;
                        r_tick_more <= 1'b0;
                        r_state     <= S_OUT;
                    end else if (o_cmd.div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        o_out_valid <= 1'b1;
                        r_tick_more <= i_stat.any_left;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        r_state     <= r_tick_more ? S_DECIDE : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The output beat is only offered while waiting in the output state.
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == S_OUT)
        else $error("output valid outside output state");
    // No new input is taken while a result is pending.
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while output pending");
    // A division start is followed by the divide state.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_DIV)
        else $error("divider start without divide state");
endmodule

@@ rtl/per_sensor_running_average_table_top.sv @@
// Top level of the per-sensor running average table.
// Depends on psra_pkg, psra_ctrl and psra_datapath.
//
// Each input beat is handled alone. A report searches the table in
// insertion order, with an index check, a registered RAM read and a
// compare for each stored entry, and returns one status beat; the input
// is ready again once that beat is taken. A tick walks the entries in the
// same steps, stopping after the last one with a nonzero count, and runs
// the divider (one quotient bit per cycle for 32 bits) for each entry
// with a nonzero count, emitting one average beat per such entry.
// The table needs no clearing after reset; it is ready at once.
module per_sensor_running_average_table_top
    import psra_pkg::*;
#(
    parameter int MAX_SENSORS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    logic [15:0] r_router_id;
    t_cmd        w_cmd;
    t_stat       w_stat;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_router_id <= '0;
        end else if (i_cfg_we) begin
            r_router_id <= i_cfg_wdata;
        end
    end

    psra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    psra_datapath #(.MAX_SENSORS(MAX_SENSORS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (i_in_data),
        .i_router_id(r_router_id),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_beat     (o_out_data)
    );
endmodule
